### rtl/core/boa_pkg.sv
// Shared types and constants for the bitmap object allocator.
`timescale 1ns / 1ps

package boa_pkg;

   localparam int OP_W       = 2;
   localparam int LEN_W      = 17;
   localparam int IDX_W      = 12;
   localparam int ST_W       = 3;
   localparam int CNT_W      = 13;
   localparam int REQ_W      = 32;
   localparam int RSP_W      = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;

   localparam int RESERVED_OBJECTS   = 2;
   localparam int RESET_OBJECT_COUNT = 4096;
   localparam logic [LEN_W-1:0] RESET_OBJECT_SIZE = 17'd2048;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_REINIT = 2'd2
   } boa_op_type;

   typedef enum logic [ST_W-1:0] {
      STAT_OK           = 3'd0,
      STAT_TOO_LARGE    = 3'd1,
      STAT_NO_MEMORY    = 3'd2,
      STAT_BAD_INDEX    = 3'd3,
      STAT_ALREADY_FREE = 3'd4
   } boa_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OBJECT_SIZE  = 1'd0,
      CSR_OBJECT_COUNT = 1'd1
   } boa_csr_type;

   typedef enum logic [2:0] {
      S_SWEEP,
      S_IDLE,
      S_PICK,
      S_ALLOC,
      S_FREAD,
      S_FREE,
      S_DONE
   } boa_state_type;

   // Update of one summary bit: the word at the given index is (non)empty.
   typedef struct packed {
      logic upd;
      logic nonempty;
   } boa_sum_ctl_type;

endpackage

### rtl/core/boa_map_ram.sv
// Free map storage: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module boa_map_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/boa_summary.sv
// Non-empty word summary with a two-level registered first-fit search.
`timescale 1ns / 1ps

module boa_summary #(
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  boa_pkg::boa_sum_ctl_type ctl,
   input  logic [AW-1:0]            upd_idx,
   output logic                     found,
   output logic [AW-1:0]            word
);

   import boa_pkg::*;

   localparam int GROUP = 16;
   localparam int GW    = $clog2(GROUP);
   localparam int NG    = (DEPTH + GROUP - 1) / GROUP;
   localparam int NGW   = (NG > 1) ? $clog2(NG) : 1;
   localparam int PAD   = NG * GROUP;
   localparam int PW    = $clog2(PAD);

   logic [PAD-1:0]  bits_ff;
   logic [PAD-1:0]  bits_in;
   logic [NG-1:0]   any_ff;
   logic [NG-1:0]   any_in;
   logic [GW-1:0]   first_ff [NG];
   logic [GW-1:0]   first_in [NG];
   logic [NGW-1:0]  grp_sel;
   logic [PW-1:0]   pick;

   always_comb begin
      bits_in = bits_ff;
      if (ctl.upd) begin
         bits_in[upd_idx] = ctl.nonempty;
      end
   end

   // Level one: any word and lowest word within each group.
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         any_in[g]   = |bits_ff[g*GROUP +: GROUP];
         first_in[g] = '0;
         for (int b = GROUP - 1; b >= 0; b--) begin
            if (bits_ff[g*GROUP + b]) begin
               first_in[g] = GW'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
      end else begin
         bits_ff <= bits_in;
      end
   end

   always_ff @(posedge clock) begin
      any_ff   <= any_in;
      first_ff <= first_in;
   end

   // Level two: lowest group that holds a free word.
   always_comb begin
      grp_sel = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (any_ff[g]) begin
            grp_sel = NGW'(g);
         end
      end
      pick  = PW'(grp_sel) * PW'(GROUP) + PW'(first_ff[grp_sel]);
      found = |any_ff;
      word  = AW'(pick);
   end

endmodule

### rtl/core/bitmap_object_allocator_core.sv
// Top level of the first-fit bitmap object allocator.
`timescale 1ns / 1ps

// First-fit allocator for a pool of fixed-size objects. One bit per object sits in
// a free map of WORD_BITS-bit words in a one-port-read, one-port-write memory; a
// summary bit per word marks the words that still hold a free object, so the
// lowest free object is found without walking the map. One word is handled at a
// time. An allocate or a free goes from acceptance to a registered result through
// a summary search or index split, a map read and a write back, and the block takes
// no new request before the last result is in the output register. A request
// refused on its fields or on a zero free count answers the cycle after it is
// accepted if the output register is free. A reinitialize rewrites the whole map,
// one map word a cycle. After reset the block runs the same pass and holds
// req_tready low meanwhile; csr writes are taken at any time. A result waits in
// an output register while the next request is taken.

module bitmap_object_allocator_core #(
   parameter int MAX_OBJECTS = 4096,
   parameter int WORD_BITS   = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // operation[1:0], request_len[18:2], object_index[30:19], zero[31]
   input  logic [boa_pkg::REQ_W-1:0]        req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status[2:0], granted_index[14:3], free_left[27:15], zero[31:28]
   output logic [boa_pkg::RSP_W-1:0]        rsp_tdata,
   input  logic                             csr_we,
   input  logic [boa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [boa_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import boa_pkg::*;

   localparam int MAP_DEPTH = (MAX_OBJECTS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int BW        = $clog2(WORD_BITS);
   localparam int IW        = $clog2(MAP_DEPTH * WORD_BITS + 1);
   localparam int EW        = ((IW > CNT_W) ? IW : CNT_W) + 1;
   localparam int DIV_SHIFT = IDX_W + $clog2(WORD_BITS);
   localparam int DIV_RECIP = (2 ** DIV_SHIFT + WORD_BITS - 1) / WORD_BITS;
   localparam int RW        = $clog2(DIV_RECIP + 1);
   localparam int PAD_W     = RSP_W - ST_W - IDX_W - CNT_W;
   localparam int RESET_LIVE_I =
      (MAX_OBJECTS < RESET_OBJECT_COUNT) ? MAX_OBJECTS : RESET_OBJECT_COUNT;
   localparam logic [CNT_W-1:0] RESET_LIVE = CNT_W'(RESET_LIVE_I);

   // Request fields
   boa_op_type        req_op;
   logic [LEN_W-1:0]  req_len;
   logic [IDX_W-1:0]  req_idx;
   logic              accept;

   // Configuration
   logic [LEN_W-1:0]  object_size_ff, object_size_in;
   logic [CNT_W-1:0]  object_count_ff, object_count_in;
   logic [CNT_W-1:0]  live_count;

   // Control and datapath registers
   boa_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [AW-1:0]     sweep_ff, sweep_in;
   logic [IW-1:0]     lo_ff, lo_in;
   logic [CNT_W-1:0]  sweep_count_ff, sweep_count_in;
   logic              reply_ff, reply_in;
   logic [AW-1:0]     word_ff, word_in;
   logic [IW-1:0]     base_ff, base_in;
   logic [BW-1:0]     bit_ff, bit_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [RSP_W-1:0]  res_data_ff, res_data_in;

   // Combinational
   logic                  sweep_last;
   logic [EW-1:0]         sweep_diff;
   logic [WORD_BITS-1:0]  sweep_word;
   logic [IDX_W+RW-1:0]   div_prod;
   logic [BW-1:0]         low_bit;
   logic                  slot_free;
   logic                  fin;
   boa_status_type        fin_status;
   logic [IDX_W-1:0]      fin_grant;
   logic [CNT_W-1:0]      fin_left;
   logic [RSP_W-1:0]      fin_data;

   // Memory and summary hookup
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [WORD_BITS-1:0]  mem_wdata;
   logic                  mem_re;
   logic [AW-1:0]         mem_raddr;
   logic [WORD_BITS-1:0]  mem_rdata;
   boa_sum_ctl_type       sum_ctl;
   logic [AW-1:0]         sum_idx;
   logic                  sum_found;
   logic [AW-1:0]         sum_word;

   boa_map_ram #(
      .DEPTH (MAP_DEPTH),
      .WIDTH (WORD_BITS)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   boa_summary #(
      .DEPTH (MAP_DEPTH)
   ) u_summary (
      .clock   (clock),
      .reset   (reset),
      .ctl     (sum_ctl),
      .upd_idx (sum_idx),
      .found   (sum_found),
      .word    (sum_word)
   );

   assign req_op  = boa_op_type'(req_tdata[1:0]);
   assign req_len = req_tdata[18:2];
   assign req_idx = req_tdata[30:19];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      object_size_in  = object_size_ff;
      object_count_in = object_count_ff;
      if (csr_we) begin
         unique case (boa_csr_type'(csr_index))
            CSR_OBJECT_SIZE:  object_size_in  = csr_wdata;
            CSR_OBJECT_COUNT: object_count_in = csr_wdata[CNT_W-1:0];
            default:          object_size_in  = object_size_ff;
         endcase
      end
   end

   // Clamp the count into [2, MAX_OBJECTS].
   always_comb begin
      if (object_count_ff < CNT_W'(RESERVED_OBJECTS)) begin
         live_count = CNT_W'(RESERVED_OBJECTS);
      end else if (object_count_ff > MAX_OBJECTS) begin
         live_count = CNT_W'(MAX_OBJECTS);
      end else begin
         live_count = object_count_ff;
      end
   end

   // Map word for the reinit pass: objects in [2, count) are free.
   always_comb begin
      sweep_last = (sweep_ff == AW'(MAP_DEPTH - 1));
      if (EW'(sweep_count_ff) > EW'(lo_ff)) begin
         sweep_diff = EW'(sweep_count_ff) - EW'(lo_ff);
      end else begin
         sweep_diff = '0;
      end
      for (int b = 0; b < WORD_BITS; b++) begin
         sweep_word[b] = (sweep_diff > EW'(b));
      end
      if (lo_ff == '0) begin
         sweep_word[RESERVED_OBJECTS-1:0] = '0;
      end
   end

   // Word index of a free request by reciprocal multiply.
   assign div_prod = (IDX_W+RW)'(req_idx) * (IDX_W+RW)'(DIV_RECIP);

   always_comb begin
      low_bit = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (mem_rdata[b]) begin
            low_bit = BW'(b);
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_SWEEP: begin
            if (sweep_last) begin
               state_in = (fin && !slot_free) ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (fin) begin
                  state_in = slot_free ? S_IDLE : S_DONE;
               end else if (req_op == OP_ALLOC) begin
                  state_in = S_PICK;
               end else if (req_op == OP_FREE) begin
                  state_in = S_FREAD;
               end else begin
                  state_in = S_SWEEP;
               end
            end
         end
         S_PICK: begin
            if (fin) begin
               state_in = slot_free ? S_IDLE : S_DONE;
            end else begin
               state_in = S_ALLOC;
            end
         end
         S_FREAD: state_in = S_FREE;
         S_ALLOC,
         S_FREE:  state_in = slot_free ? S_IDLE : S_DONE;
         S_DONE:  state_in = slot_free ? S_IDLE : S_DONE;
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs and datapath
   always_comb begin
      fin            = 1'b0;
      fin_status     = STAT_OK;
      fin_grant      = '0;
      fin_left       = count_ff;
      mem_we         = 1'b0;
      mem_waddr      = sweep_ff;
      mem_wdata      = sweep_word;
      mem_re         = 1'b0;
      mem_raddr      = word_ff;
      sum_ctl        = '0;
      sum_idx        = sweep_ff;
      count_in       = count_ff;
      sweep_in       = sweep_ff;
      lo_in          = lo_ff;
      sweep_count_in = sweep_count_ff;
      reply_in       = reply_ff;
      word_in        = word_ff;
      base_in        = base_ff;
      bit_in         = bit_ff;
      idx_in         = idx_ff;

      unique case (state_ff)
         S_SWEEP: begin
            mem_we           = 1'b1;
            sum_ctl.upd      = 1'b1;
            sum_ctl.nonempty = |sweep_word;
            sweep_in         = sweep_ff + AW'(1);
            lo_in            = lo_ff + IW'(WORD_BITS);
            if (sweep_last) begin
               fin      = reply_ff;
               reply_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_ALLOC: begin
                     if (req_len > object_size_ff) begin
                        fin        = 1'b1;
                        fin_status = STAT_TOO_LARGE;
                     end else if (count_ff == '0) begin
                        fin        = 1'b1;
                        fin_status = STAT_NO_MEMORY;
                     end
                  end
                  OP_FREE: begin
                     if (req_idx < IDX_W'(RESERVED_OBJECTS) ||
                         CNT_W'(req_idx) >= live_count) begin
                        fin        = 1'b1;
                        fin_status = STAT_BAD_INDEX;
                     end
                     word_in = AW'(div_prod >> DIV_SHIFT);
                     idx_in  = req_idx;
                  end
                  OP_REINIT: begin
                     sweep_in       = '0;
                     lo_in          = '0;
                     sweep_count_in = live_count;
                     count_in       = live_count - CNT_W'(RESERVED_OBJECTS);
                     reply_in       = 1'b1;
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         S_PICK: begin
            if (sum_found) begin
               mem_re    = 1'b1;
               mem_raddr = sum_word;
               word_in   = sum_word;
               base_in   = IW'(sum_word * WORD_BITS);
            end else begin
               fin        = 1'b1;
               fin_status = STAT_NO_MEMORY;
            end
         end
         S_ALLOC: begin
            fin = 1'b1;
            if (mem_rdata == '0) begin
               fin_status = STAT_NO_MEMORY;
            end else begin
               // Clear the lowest set bit.
               mem_we           = 1'b1;
               mem_waddr        = word_ff;
               mem_wdata        = mem_rdata & (mem_rdata - WORD_BITS'(1));
               sum_ctl.upd      = 1'b1;
               sum_ctl.nonempty = |(mem_rdata & (mem_rdata - WORD_BITS'(1)));
               sum_idx          = word_ff;
               count_in         = count_ff - CNT_W'(1);
               fin_grant        = IDX_W'(base_ff + IW'(low_bit));
               fin_left         = count_ff - CNT_W'(1);
            end
         end
         S_FREAD: begin
            mem_re = 1'b1;
            bit_in = BW'(idx_ff - IDX_W'(word_ff * WORD_BITS));
         end
         S_FREE: begin
            fin = 1'b1;
            if (mem_rdata[bit_ff]) begin
               fin_status = STAT_ALREADY_FREE;
            end else begin
               mem_we           = 1'b1;
               mem_waddr        = word_ff;
               mem_wdata        = mem_rdata | (WORD_BITS'(1) << bit_ff);
               sum_ctl.upd      = 1'b1;
               sum_ctl.nonempty = 1'b1;
               sum_idx          = word_ff;
               count_in         = count_ff + CNT_W'(1);
               fin_left         = count_ff + CNT_W'(1);
            end
         end
         S_DONE: begin
            fin = 1'b0;
         end
         default: begin
            fin = 1'b0;
         end
      endcase
   end

   assign fin_data = {{PAD_W{1'b0}}, fin_left, fin_grant, fin_status};

   // Result goes straight to the output register when it is free, else hold it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      res_data_in  = res_data_ff;
      if (fin && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = fin_data;
      end else if (fin) begin
         res_data_in  = fin_data;
      end else if (state_ff == S_DONE && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_SWEEP;
         object_size_ff  <= RESET_OBJECT_SIZE;
         object_count_ff <= CNT_W'(RESET_OBJECT_COUNT);
         count_ff        <= RESET_LIVE - CNT_W'(RESERVED_OBJECTS);
         sweep_ff        <= '0;
         lo_ff           <= '0;
         sweep_count_ff  <= RESET_LIVE;
         reply_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         object_size_ff  <= object_size_in;
         object_count_ff <= object_count_in;
         count_ff        <= count_in;
         sweep_ff        <= sweep_in;
         lo_ff           <= lo_in;
         sweep_count_ff  <= sweep_count_in;
         reply_ff        <= reply_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      base_ff     <= base_in;
      bit_ff      <= bit_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
      res_data_ff <= res_data_in;
   end

endmodule

### bench/tb.sv
// Self-checking bench for the bitmap object allocator core.
`timescale 1ns / 1ps

module tb;
   import boa_pkg::*;

   localparam int MAP_WORDS       = 128;
   localparam int WORD_SIZE       = 32;
   localparam int POOL_LIMIT      = 4096;
   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int HOLD_CYCLES     = 300;
   localparam int QUIET_LIMIT     = 2000;
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   // one reply word, last field in the lowest bits
   typedef struct packed {
      logic [CNT_W-1:0] free_left;
      logic [IDX_W-1:0] granted;
      logic [ST_W-1:0]  status;
   } alloc_reply_type;

   typedef struct packed {
      bit                    is_csr;
      boa_csr_type           reg_sel;
      logic [CSR_DATA_W-1:0] reg_val;
      logic [OP_W-1:0]       op;
      logic [LEN_W-1:0]      len;
      logic [IDX_W-1:0]      idx;
      bit                    typed;
      alloc_reply_type       want;
   } script_row_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_W-1:0]        req_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_W-1:0]        rsp_tdata;
   logic                    csr_we;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   // pool as the bench sees it
   logic [WORD_SIZE-1:0]    pool_map [MAP_WORDS];
   logic [CNT_W-1:0]        pool_free;
   logic [LEN_W-1:0]        len_limit;
   logic [CNT_W-1:0]        obj_count;

   alloc_reply_type         replies_owed [$];
   logic [IDX_W-1:0]        held [$];
   script_row_type          script [$];
   int                      bad_replies;
   int                      quiet;
   bit                      gaps_on;
   bit                      stalls_on;
   bit                      long_hold_req;
   int                      stall_left;

   bitmap_object_allocator_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int live_limit();
      int c;
      c = obj_count;
      if (c < RESERVED_OBJECTS) c = RESERVED_OBJECTS;
      if (c > POOL_LIMIT) c = POOL_LIMIT;
      return c;
   endfunction

   task automatic rebuild_pool();
      int lim;
      lim = live_limit();
      for (int w = 0; w < MAP_WORDS; w++) pool_map[w] = '0;
      for (int k = RESERVED_OBJECTS; k < lim; k++) pool_map[k / WORD_SIZE][k % WORD_SIZE] = 1'b1;
      pool_free = CNT_W'(lim - RESERVED_OBJECTS);
   endtask

   // Advance the pool by one request and give the reply it should produce.
   task automatic pool_apply(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] len,
                             input logic [IDX_W-1:0] idx, output alloc_reply_type r);
      bit found;
      int lim;
      r.status  = STAT_OK;
      r.granted = '0;
      case (op)
         OP_ALLOC: begin
            if (len > len_limit) begin
               r.status = STAT_TOO_LARGE;
            end else if (pool_free == 0) begin
               r.status = STAT_NO_MEMORY;
            end else begin
               found = 1'b0;
               for (int w = 0; w < MAP_WORDS && !found; w++) begin
                  for (int b = 0; b < WORD_SIZE && !found; b++) begin
                     if (pool_map[w][b]) begin
                        pool_map[w][b] = 1'b0;
                        pool_free = pool_free - 1'b1;
                        r.granted = IDX_W'(w * WORD_SIZE + b);
                        found = 1'b1;
                     end
                  end
               end
               if (!found) r.status = STAT_NO_MEMORY;
            end
         end
         OP_FREE: begin
            lim = live_limit();
            if (idx < RESERVED_OBJECTS || idx >= lim) begin
               r.status = STAT_BAD_INDEX;
            end else if (pool_map[idx / WORD_SIZE][idx % WORD_SIZE]) begin
               r.status = STAT_ALREADY_FREE;
            end else begin
               pool_map[idx / WORD_SIZE][idx % WORD_SIZE] = 1'b1;
               pool_free = pool_free + 1'b1;
            end
         end
         OP_REINIT: rebuild_pool();
         default: ;
      endcase
      r.free_left = pool_free;
   endtask

   task automatic write_reg(input boa_csr_type which, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= which;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (which == CSR_OBJECT_SIZE) len_limit = val;
      else obj_count = val[CNT_W-1:0];
   endtask

   // Drop valid and hold until every reply is back.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (replies_owed.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic offer_word(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] len,
                             input logic [IDX_W-1:0] idx, input alloc_reply_type want);
      int gap;
      replies_owed.push_back(want);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, idx, len, op};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic issue(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] len,
                        input logic [IDX_W-1:0] idx);
      alloc_reply_type r;
      pool_apply(op, len, idx, r);
      if (op == OP_ALLOC && r.status == STAT_OK) held.push_back(r.granted);
      if (op == OP_REINIT) held.delete();
      offer_word(op, len, idx, r);
   endtask

   task automatic random_item();
      int pick, k, lim;
      logic [OP_W-1:0]  op;
      logic [LEN_W-1:0] len;
      logic [IDX_W-1:0] idx;
      pick = $urandom_range(0, 99);
      len  = LEN_W'($urandom);
      idx  = IDX_W'($urandom);
      if (pick < 50) begin
         op = OP_ALLOC;
         k  = $urandom_range(0, 19);
         if (k < 12) len = LEN_W'($urandom_range(0, len_limit));
         else if (k < 15) len = (k == 12 || len_limit == '1) ? len_limit : len_limit + 1'b1;
      end else if (pick < 94) begin
         op = OP_FREE;
         if (held.size() != 0 && $urandom_range(0, 9) < 7) begin
            k   = $urandom_range(0, held.size() - 1);
            idx = held[k];
            held.delete(k);
         end else if ($urandom_range(0, 1) == 0) begin
            lim = live_limit() + 1;
            if (lim > POOL_LIMIT - 1) lim = POOL_LIMIT - 1;
            idx = IDX_W'($urandom_range(0, lim));
         end
      end else if (pick < 97) begin
         op = OP_REINIT;
      end else begin
         op = OP_SPARE;
      end
      issue(op, len, idx);
   endtask

   function automatic script_row_type item_row(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
                                                logic [IDX_W-1:0] idx);
      script_row_type s;
      s        = '0;
      s.op     = op;
      s.len    = len;
      s.idx    = idx;
      return s;
   endfunction

   function automatic script_row_type typed_row(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
                                                 logic [IDX_W-1:0] idx, boa_status_type st,
                                                 int gi, int left);
      script_row_type s;
      s                = item_row(op, len, idx);
      s.typed          = 1'b1;
      s.want.status    = st;
      s.want.granted   = IDX_W'(gi);
      s.want.free_left = CNT_W'(left);
      return s;
   endfunction

   function automatic script_row_type csr_row(boa_csr_type which,
                                               logic [CSR_DATA_W-1:0] val);
      script_row_type s;
      s         = '0;
      s.is_csr  = 1'b1;
      s.reg_sel = which;
      s.reg_val = val;
      return s;
   endfunction

   task automatic report(input alloc_reply_type want, input alloc_reply_type got);
      bad_replies++;
      if (bad_replies <= 10)
         $display("mismatch at %0t: status %0d/%0d granted %0d/%0d free_left %0d/%0d (exp/got)",
                  $realtime, want.status, got.status, want.granted, got.granted,
                  want.free_left, got.free_left);
   endtask

   // check replies
   always @(posedge clock) begin : reply_check
      alloc_reply_type got;
      alloc_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = alloc_reply_type'(rsp_tdata[ST_W+IDX_W+CNT_W-1:0]);
         if (replies_owed.size() == 0) begin
            bad_replies++;
            if (bad_replies <= 10)
               $display("unexpected reply at %0t: status %0d granted %0d free_left %0d",
                        $realtime, got.status, got.granted, got.free_left);
         end else begin
            want = replies_owed.pop_front();
            if (got.status != want.status || got.granted != want.granted ||
                got.free_left != want.free_left)
               report(want, got);
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         stall_left    = HOLD_CYCLES;
      end else if (stall_left == 0 && stalls_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 11);
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      alloc_reply_type r;
      logic [LEN_W-1:0] sz;
      logic [CSR_DATA_W-1:0] cnt;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      bad_replies   = 0;
      quiet         = 0;
      gaps_on       = 1'b1;
      stalls_on     = 1'b1;
      long_hold_req = 1'b0;
      stall_left    = 0;
      len_limit     = RESET_OBJECT_SIZE;
      obj_count     = CNT_W'(RESET_OBJECT_COUNT);
      rebuild_pool();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      script.push_back(typed_row(OP_ALLOC, 0, 0, STAT_OK, 2, 4093));
      script.push_back(typed_row(OP_ALLOC, 2049, 0, STAT_TOO_LARGE, 0, 4093));
      script.push_back(typed_row(OP_ALLOC, 2048, 0, STAT_OK, 3, 4092));
      script.push_back(typed_row(OP_FREE, 0, 0, STAT_BAD_INDEX, 0, 4092));
      script.push_back(typed_row(OP_FREE, 0, 1, STAT_BAD_INDEX, 0, 4092));
      script.push_back(typed_row(OP_FREE, 0, 4095, STAT_ALREADY_FREE, 0, 4092));
      script.push_back(typed_row(OP_FREE, 0, 3, STAT_OK, 0, 4093));
      script.push_back(typed_row(OP_FREE, 0, 3, STAT_ALREADY_FREE, 0, 4093));
      script.push_back(item_row(OP_SPARE, '1, '1));
      script.push_back(typed_row(OP_ALLOC, '1, 0, STAT_TOO_LARGE, 0, 4093));
      script.push_back(typed_row(OP_REINIT, 0, 0, STAT_OK, 0, 4094));
      script.push_back(csr_row(CSR_OBJECT_SIZE, 64));
      script.push_back(csr_row(CSR_OBJECT_COUNT, 2));
      // count shrunk without reinit: the scan still hands out object 2
      script.push_back(item_row(OP_ALLOC, 64, 0));
      script.push_back(typed_row(OP_ALLOC, 65, 0, STAT_TOO_LARGE, 0, 4093));
      script.push_back(typed_row(OP_FREE, 0, 2, STAT_BAD_INDEX, 0, 4093));
      script.push_back(typed_row(OP_REINIT, 0, 0, STAT_OK, 0, 0));
      script.push_back(typed_row(OP_ALLOC, 0, 0, STAT_NO_MEMORY, 0, 0));
      // too large wins over out of memory
      script.push_back(typed_row(OP_ALLOC, 65, 0, STAT_TOO_LARGE, 0, 0));
      script.push_back(csr_row(CSR_OBJECT_SIZE, '1));
      script.push_back(csr_row(CSR_OBJECT_COUNT, 8191));
      script.push_back(typed_row(OP_FREE, 0, 4095, STAT_OK, 0, 1));
      script.push_back(item_row(OP_ALLOC, '1, 0));
      script.push_back(typed_row(OP_FREE, 0, 4095, STAT_OK, 0, 1));
      script.push_back(typed_row(OP_FREE, 0, 4095, STAT_ALREADY_FREE, 0, 1));
      script.push_back(csr_row(CSR_OBJECT_SIZE, 0));
      script.push_back(csr_row(CSR_OBJECT_COUNT, 0));
      script.push_back(typed_row(OP_REINIT, 0, 0, STAT_OK, 0, 0));
      script.push_back(typed_row(OP_ALLOC, 0, 0, STAT_NO_MEMORY, 0, 0));
      script.push_back(typed_row(OP_ALLOC, 1, 0, STAT_TOO_LARGE, 0, 0));
      script.push_back(typed_row(OP_FREE, 0, 2, STAT_BAD_INDEX, 0, 0));

      foreach (script[n]) begin
         if (script[n].is_csr) begin
            drain();
            write_reg(script[n].reg_sel, script[n].reg_val);
         end else begin
            pool_apply(script[n].op, script[n].len, script[n].idx, r);
            offer_word(script[n].op, script[n].len, script[n].idx,
                       script[n].typed ? script[n].want : r);
         end
      end

      // random phases, each under its own register setting
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: begin sz = 2048;                        cnt = 4096; end
            1: begin sz = 64;                          cnt = 40;   end
            2: begin sz = 131008;                      cnt = 70;   end
            3: begin sz = LEN_W'($urandom_range(64, 131008)); cnt = 3; end
            4: begin sz = LEN_W'($urandom_range(64, 131008)); cnt = 100; end
            5: begin sz = '1;                          cnt = 8191; end
            6: begin sz = 64;                          cnt = 33;   end
            7: begin sz = LEN_W'($urandom_range(64, 131008)); cnt = 1; end
            8: begin sz = LEN_W'($urandom_range(64, 131008));
                     cnt = CSR_DATA_W'($urandom_range(2, 200)); end
            default: begin sz = 500;                   cnt = 50;   end
         endcase
         write_reg(CSR_OBJECT_SIZE, sz);
         write_reg(CSR_OBJECT_COUNT, cnt);
         gaps_on   = (ph != 3) && (ph != PHASES - 1);
         stalls_on = (ph != 6) && (ph != PHASES - 1);
         if (ph == 2) long_hold_req = 1'b1;
         if ($urandom_range(0, 3) != 0) issue(OP_REINIT, LEN_W'($urandom), IDX_W'($urandom));
         repeat (ITEMS_PER_PHASE) random_item();
      end

      drain();
      repeat (40) @(posedge clock);
      if (bad_replies == 0 && replies_owed.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
